// ===== rtl/handheld_timer_divider_tima_defines.svh =====
// Assertion macros shared by the timer block's RTL.
`ifndef HANDHELD_TIMER_DIVIDER_TIMA_DEFINES_SVH
`define HANDHELD_TIMER_DIVIDER_TIMA_DEFINES_SVH

// Checks that cons holds in the same cycle as ante, outside reset.
`define HTDT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante, outside reset.
`define HTDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/htdt_pkg.sv =====
// Shared constants and helpers for the handheld timer and divider block.
package htdt_pkg;

  localparam int unsigned SysW    = 16;
  localparam int unsigned PreW    = 16;
  localparam int unsigned CntW    = 8;
  localparam int unsigned CycW    = 6;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [SysW-1:0] SysReset = 16'hABCC;
  localparam logic [SysW-1:0] SysLimit = 16'hFFFF;
  localparam logic [PreW-1:0] PreMax   = 16'hFFFF;
  localparam logic [CntW-1:0] CntMax   = 8'hFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTimerEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgClockSelect = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgReloadValue = 2'd2;

  // Clock select codes, named by their prescaler period.
  localparam logic [1:0] ClkSel1024 = 2'd0;
  localparam logic [1:0] ClkSel16   = 2'd1;
  localparam logic [1:0] ClkSel64   = 2'd2;
  localparam logic [1:0] ClkSel256  = 2'd3;

  // Prescaler period for each clock select code.
  function automatic logic [PreW-1:0] period_of(input logic [1:0] sel);
    logic [PreW-1:0] per;
    case (sel)
      ClkSel1024: per = 16'd1024;
      ClkSel16:   per = 16'd16;
      ClkSel64:   per = 16'd64;
      ClkSel256:  per = 16'd256;
      default:    per = 16'd1024;
    endcase
    return per;
  endfunction

endpackage

// ===== rtl/handheld_timer_divider_tima.sv =====
// Top level of the handheld timer: free-running divider and reloadable 8-bit counter.
//
// One tick request is accepted per clock cycle unless stalled, and each produces exactly
// one result: the request is captured in an input register, the divider, prescaler and
// counter update is a few adds and compares, and the result lands in the output register.
// The state registers are updated once per tick in that single pass, so back-to-back ticks
// sustain one per cycle while the output is taken. A stalled output stalls the input only
// when both registers are full. Configuration writes are always ready and take effect on
// the next tick that is processed. No clearing pass is needed after reset.
`include "handheld_timer_divider_tima_defines.svh"

module handheld_timer_divider_tima (
  input  logic                            clk,
  input  logic                            rst_n,
  // tdata, from bit 0: cycles[5:0], tima_write, tima_write_value[7:0], flag_write,
  // flag_write_value, glitch, zero padding.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [htdt_pkg::InDataW-1:0]    in_tdata,
  // tdata, from bit 0: counter_value[7:0], divider_value[7:0], timer_interrupt,
  // phase_out[1:0], zero padding.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [htdt_pkg::OutDataW-1:0]   out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htdt_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [htdt_pkg::CfgDataW-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    PH_COUNTING = 2'd0,
    PH_OVERFLOW = 2'd1,
    PH_LOADING  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                        glitch;
    logic                        flag_write_value;
    logic                        flag_write;
    logic [htdt_pkg::CntW-1:0]   tima_write_value;
    logic                        tima_write;
    logic [htdt_pkg::CycW-1:0]   cycles;
  } tick_t;

  // Configuration registers.
  logic                        timer_enable_r;
  logic [1:0]                  clock_select_r;
  logic [htdt_pkg::CntW-1:0]   reload_value_r;

  // Timer state.
  logic [htdt_pkg::SysW-1:0]   system_count_r, system_count_nxt;
  logic [htdt_pkg::PreW-1:0]   prescale_count_r, prescale_count_nxt;
  logic [htdt_pkg::CntW-1:0]   timer_count_r, timer_count_nxt;
  phase_t                      phase_r, phase_nxt;
  logic                        irq_nxt;

  // Pipeline registers.
  logic                        s1_valid_r;
  tick_t                       s1_tick_r;
  logic                        out_valid_r;
  logic [htdt_pkg::OutDataW-1:0] out_data_r;

  logic                        out_free;
  logic                        advance;
  logic                        in_fire;

  logic [htdt_pkg::SysW:0]     sys_sum;
  logic [htdt_pkg::PreW:0]     pre_sum;
  logic [htdt_pkg::PreW-1:0]   pre_sat;
  logic [htdt_pkg::PreW-1:0]   period;
  logic [htdt_pkg::CntW-1:0]   cnt_base;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign period = htdt_pkg::period_of(clock_select_r);

  always_comb begin
    sys_sum = {1'b0, system_count_r} + {{(htdt_pkg::SysW + 1 - htdt_pkg::CycW){1'b0}},
                                        s1_tick_r.cycles};
    if (sys_sum >= {1'b0, htdt_pkg::SysLimit}) begin
      system_count_nxt = '0;
    end else begin
      system_count_nxt = sys_sum[htdt_pkg::SysW-1:0];
    end

    pre_sum = {1'b0, prescale_count_r} + {{(htdt_pkg::PreW + 1 - htdt_pkg::CycW){1'b0}},
                                          s1_tick_r.cycles};
    pre_sat = pre_sum[htdt_pkg::PreW] ? htdt_pkg::PreMax : pre_sum[htdt_pkg::PreW-1:0];

    cnt_base           = s1_tick_r.tima_write ? s1_tick_r.tima_write_value : timer_count_r;
    prescale_count_nxt = prescale_count_r;
    timer_count_nxt    = timer_count_r;
    phase_nxt          = PH_COUNTING;
    irq_nxt            = 1'b0;

    case (phase_r)
      PH_OVERFLOW: begin
        timer_count_nxt = cnt_base == timer_count_r && !s1_tick_r.tima_write ?
                          reload_value_r : s1_tick_r.tima_write_value;
        phase_nxt       = PH_LOADING;
      end
      PH_LOADING: begin
        if (s1_tick_r.tima_write) begin
          timer_count_nxt = s1_tick_r.glitch ? s1_tick_r.tima_write_value : reload_value_r;
        end
        // A flag write of zero in the same tick cancels the interrupt.
        irq_nxt = !s1_tick_r.glitch &&
                  !(s1_tick_r.flag_write && !s1_tick_r.flag_write_value);
      end
      default: begin
        // Counting; the unused code is handled the same way.
        timer_count_nxt = cnt_base;
        if (timer_enable_r) begin
          prescale_count_nxt = pre_sat;
          if (pre_sat >= period) begin
            prescale_count_nxt = pre_sat - period;
            if (cnt_base == htdt_pkg::CntMax) begin
              timer_count_nxt = '0;
              phase_nxt       = PH_OVERFLOW;
            end else begin
              timer_count_nxt = cnt_base + 1'b1;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_enable_r   <= 1'b0;
      clock_select_r   <= '0;
      reload_value_r   <= '0;
      system_count_r   <= htdt_pkg::SysReset;
      prescale_count_r <= '0;
      timer_count_r    <= '0;
      phase_r          <= PH_COUNTING;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          htdt_pkg::CfgTimerEnable: timer_enable_r <= cfg_data[0];
          htdt_pkg::CfgClockSelect: clock_select_r <= cfg_data[1:0];
          htdt_pkg::CfgReloadValue: reload_value_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        system_count_r   <= system_count_nxt;
        prescale_count_r <= prescale_count_nxt;
        timer_count_r    <= timer_count_nxt;
        phase_r          <= phase_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tick_r <= tick_t'(in_tdata[$bits(tick_t)-1:0]);
    end
    if (advance) begin
      out_data_r <= {{(htdt_pkg::OutDataW - 19){1'b0}}, phase_nxt, irq_nxt,
                     system_count_nxt[htdt_pkg::SysW-1:8], timer_count_nxt};
    end
  end

  `HTDT_ASSERT_SAME(a_phase_legal, 1'b1, phase_r != 2'd3, "timer phase reached unused code")
  `HTDT_ASSERT_NEXT(a_overflow_to_loading, advance && phase_r == PH_OVERFLOW,
                    phase_r == PH_LOADING, "overflow phase did not move to loading")
  `HTDT_ASSERT_SAME(a_irq_only_after_load, out_tvalid && out_tdata[16],
                    out_tdata[18:17] == PH_COUNTING, "interrupt outside loading exit")
  `HTDT_ASSERT_SAME(a_overflow_reads_zero, out_tvalid && out_tdata[18:17] == PH_OVERFLOW,
                    out_tdata[7:0] == 8'd0, "counter not zero in overflow phase")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the handheld timer with its divider, counter and reload logic.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [1:0] {
    PhaseCounting = 2'd0,
    PhaseOverflow = 2'd1,
    PhaseLoading  = 2'd2
  } timer_phase_t;

  // Settings of the random phases; a reload of -1 picks a random value.
  localparam int NumPhases = 9;
  localparam bit         PhEnable [NumPhases] = '{1, 1, 0, 1, 1, 1, 0, 1, 1};
  localparam logic [1:0] PhSelect [NumPhases] =
    '{htdt_pkg::ClkSel16, htdt_pkg::ClkSel1024, htdt_pkg::ClkSel256, htdt_pkg::ClkSel64,
      htdt_pkg::ClkSel256, htdt_pkg::ClkSel16, htdt_pkg::ClkSel64, htdt_pkg::ClkSel64,
      htdt_pkg::ClkSel16};
  localparam int         PhReload [NumPhases] = '{255, 0, -1, -1, 0, -1, 255, -1, -1};
  localparam int PhaseItems = 60;
  localparam int LongItems = 90;

  typedef struct {
    logic [5:0] cycles;
    logic       tima_write;
    logic [7:0] tima_value;
    logic       flag_write;
    logic       flag_value;
    logic       glitch;
  } tick_req_t;

  typedef struct {
    logic [7:0] counter;
    logic [7:0] divider;
    logic       irq;
    logic [1:0] phase;
  } tick_res_t;

  class tima_scoreboard;
    logic          timer_enable;
    logic [1:0]    clock_select;
    logic [7:0]    reload_value;
    logic [15:0]   system_count;
    logic [15:0]   prescale_count;
    logic [7:0]    timer_count;
    timer_phase_t  phase;
    tick_res_t     expected_results[$];
    int            mismatches;

    function new();
      timer_enable   = 1'b0;
      clock_select   = htdt_pkg::ClkSel1024;
      reload_value   = 8'h00;
      system_count   = htdt_pkg::SysReset;
      prescale_count = '0;
      timer_count    = '0;
      phase          = PhaseCounting;
      mismatches     = 0;
    endfunction

    function void apply_cfg(logic [htdt_pkg::CfgIdxW-1:0] idx,
                            logic [htdt_pkg::CfgDataW-1:0] val);
      case (idx)
        htdt_pkg::CfgTimerEnable: timer_enable = val[0];
        htdt_pkg::CfgClockSelect: clock_select = val[1:0];
        htdt_pkg::CfgReloadValue: reload_value = val;
        default: ;
      endcase
    endfunction

    function logic [16:0] period();
      case (clock_select)
        htdt_pkg::ClkSel16:  return 17'd16;
        htdt_pkg::ClkSel64:  return 17'd64;
        htdt_pkg::ClkSel256: return 17'd256;
        default:             return 17'd1024;
      endcase
    endfunction

    // Advances the timer state by one accepted request and queues the result it yields.
    function void note_request(tick_req_t t);
      logic [16:0] sum;
      logic [16:0] pre;
      tick_res_t   r;
      sum = {1'b0, system_count} + 17'(t.cycles);
      system_count = (sum >= 17'(htdt_pkg::SysLimit)) ? 16'h0000 : sum[15:0];
      r.irq = 1'b0;
      case (phase)
        PhaseOverflow: begin
          timer_count = t.tima_write ? t.tima_value : reload_value;
          phase = PhaseLoading;
        end
        PhaseLoading: begin
          if (t.tima_write) timer_count = t.glitch ? t.tima_value : reload_value;
          // Clearing the flag in the same tick swallows the interrupt.
          if (!t.glitch && !(t.flag_write && !t.flag_value)) r.irq = 1'b1;
          phase = PhaseCounting;
        end
        default: begin
          phase = PhaseCounting;
          if (t.tima_write) timer_count = t.tima_value;
          if (timer_enable) begin
            pre = {1'b0, prescale_count} + 17'(t.cycles);
            if (pre > 17'(htdt_pkg::PreMax)) pre = 17'(htdt_pkg::PreMax);
            if (pre >= period()) begin
              pre = pre - period();
              if (timer_count == htdt_pkg::CntMax) begin
                timer_count = 8'h00;
                phase = PhaseOverflow;
              end else begin
                timer_count = timer_count + 8'd1;
              end
            end
            prescale_count = pre[15:0];
          end
        end
      endcase
      r.counter = timer_count;
      r.divider = system_count[15:8];
      r.phase   = phase;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [htdt_pkg::OutDataW-1:0] d);
      tick_res_t want;
      tick_res_t got;
      got.counter = d[7:0];
      got.divider = d[15:8];
      got.irq     = d[16];
      got.phase   = d[18:17];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %h", d);
        return;
      end
      want = expected_results.pop_front();
      if (got.counter !== want.counter || got.divider !== want.divider ||
          got.irq !== want.irq || got.phase !== want.phase) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: counter %h/%h divider %h/%h irq %b/%b phase %0d/%0d %s",
                   $realtime, want.counter, got.counter, want.divider, got.divider,
                   want.irq, got.irq, want.phase, got.phase, "(expected/actual)");
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [htdt_pkg::InDataW-1:0]        in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [htdt_pkg::OutDataW-1:0]       out_tdata;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [htdt_pkg::CfgIdxW-1:0]        cfg_index = '0;
  logic [htdt_pkg::CfgDataW-1:0]       cfg_data = '0;

  int in_gap_pct = 9;
  int out_gap_pct = 50;
  tima_scoreboard sb = new();

  handheld_timer_divider_tima dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= out_gap_pct);
  end

  task automatic send_tick(input tick_req_t t);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, t.glitch, t.flag_value, t.flag_write, t.tima_value, t.tima_write,
                  t.cycles};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(t);
  endtask

  task automatic send_fields(input logic [5:0] cyc, input logic wr, input logic [7:0] wval,
                             input logic fwr, input logic fval, input logic gl);
    tick_req_t t;
    t.cycles     = cyc;
    t.tima_write = wr;
    t.tima_value = wval;
    t.flag_write = fwr;
    t.flag_value = fval;
    t.glitch     = gl;
    send_tick(t);
  endtask

  task automatic write_cfg(input logic [htdt_pkg::CfgIdxW-1:0] idx,
                           input logic [htdt_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_cfg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops the input and lets every outstanding result come back before the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random tick biased toward counter writes near the top, so overflows come often.
  function automatic tick_req_t rand_tick(input bit long_run);
    tick_req_t t;
    int        sel;
    sel = $urandom_range(7);
    if (long_run) t.cycles = 6'($urandom_range(63, 40));
    else if (sel == 0) t.cycles = 6'd0;
    else if (sel == 1) t.cycles = 6'd63;
    else t.cycles = 6'($urandom_range(63));
    t.tima_write = long_run ? ($urandom_range(19) == 0) : ($urandom_range(4) == 0);
    t.tima_value = $urandom_range(1) ? 8'($urandom_range(255, 248)) : 8'($urandom_range(255));
    t.flag_write = ($urandom_range(2) == 0);
    t.flag_value = 1'($urandom_range(1));
    t.glitch     = ($urandom_range(2) == 0);
    return t;
  endfunction

  initial begin
    int p;
    int n;
    int rl;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // With the timer off, writes land but nothing counts.
    send_fields(6'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(6'd63, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_fields(6'd63, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1);
    drain();
    write_cfg(htdt_pkg::CfgTimerEnable, 8'd1);
    write_cfg(htdt_pkg::CfgClockSelect, 8'(htdt_pkg::ClkSel16));
    write_cfg(htdt_pkg::CfgReloadValue, 8'hAB);
    // Overflow with a write during the delay tick, then a write overridden while loading.
    send_fields(6'd16, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_fields(6'd0, 1'b1, 8'h55, 1'b0, 1'b0, 1'b0);
    send_fields(6'd0, 1'b1, 8'h66, 1'b0, 1'b0, 1'b0);
    // Glitch while loading keeps the written value and drops the interrupt.
    send_fields(6'd16, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_fields(6'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(6'd0, 1'b1, 8'h77, 1'b0, 1'b0, 1'b1);
    // Clearing the flag while loading drops the interrupt; setting it does not.
    send_fields(6'd16, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_fields(6'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(6'd5, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
    send_fields(6'd16, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0);
    send_fields(6'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(6'd63, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0);
    send_fields(6'd15, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(6'd1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    send_fields(6'd63, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1);

    for (p = 0; p < NumPhases; p++) begin
      drain();
      in_gap_pct  = (p < 3) ? 9 : (p < 6) ? 50 : 0;
      out_gap_pct = (p < 3) ? 50 : (p < 6) ? 9 : 0;
      rl = (PhReload[p] < 0) ? $urandom_range(255) : PhReload[p];
      write_cfg(htdt_pkg::CfgTimerEnable, 8'(PhEnable[p]));
      write_cfg(htdt_pkg::CfgClockSelect, 8'(PhSelect[p]));
      write_cfg(htdt_pkg::CfgReloadValue, 8'(rl));
      for (n = 0; n < PhaseItems; n++) send_tick(rand_tick(1'b0));
    end

    // Run of large ticks on the fastest period, so the prescaler climbs far above its period.
    drain();
    write_cfg(htdt_pkg::CfgTimerEnable, 8'd1);
    write_cfg(htdt_pkg::CfgClockSelect, 8'(htdt_pkg::ClkSel16));
    write_cfg(htdt_pkg::CfgReloadValue, 8'($urandom_range(255)));
    for (n = 0; n < LongItems; n++) send_tick(rand_tick(1'b1));

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("handheld_timer_divider_tima verification clean");
    end else begin
      $display("handheld_timer_divider_tima verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("handheld_timer_divider_tima verification failed");
    $finish;
  end

endmodule
